// ----- sv/incremental_pid_position_loop_core_assert.svh -----
// Assertion macros shared by the position loop RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef INCREMENTAL_PID_POSITION_LOOP_CORE_ASSERT_SVH
`define INCREMENTAL_PID_POSITION_LOOP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPID_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ipid_pkg.sv -----
package ipid_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int AXIS_W      = 2;
    localparam int POS_W       = 32;
    localparam int ACC_W       = 32;
    localparam int GAIN_W      = 10;
    localparam int MODE_W      = 2;
    localparam int PWM_W       = 16;
    localparam int SPEED_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Number of axes that have a speed limit register.
    localparam int LIMIT_REGS = 3;

    // Parameter defaults.
    localparam int DEFAULT_AXES           = 3;
    localparam int DEFAULT_POSITION_WIDTH = 32;

    // Register indices.
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_LIMIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_A = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_B = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT_C = 3'd7;

    // Loop modes.
    localparam logic [MODE_W-1:0] MODE_DIRECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd1;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 10'd4;
    localparam logic [PWM_W-1:0]  PWM_LIMIT_RESET = 16'd3500;

    typedef struct packed {
        logic [AXIS_W-1:0]       axis;
        logic signed [POS_W-1:0] target_position;
        logic signed [POS_W-1:0] measured_position;
    } pid_in_t;

    typedef struct packed {
        logic [AXIS_W-1:0]       axis_out;
        logic signed [ACC_W-1:0] velocity_command;
        logic                    velocity_valid;
        logic [PWM_W-1:0]        pwm_forward;
        logic [PWM_W-1:0]        pwm_reverse;
        logic                    pwm_valid;
    } pid_out_t;

endpackage

// ----- sv/incremental_pid_position_loop_core.sv -----
// Incremental PID position loop for several motor axes. Each input transaction is one control
// tick for one axis. It carries a target and a measured position. The block forms the error,
// adds kp*(e-e1) + ki*e + kd*(e-2*e1+e2) to that axis's wrapping 32-bit accumulator, and returns
// one result transaction. In velocity mode the result holds the accumulator clamped to the
// axis speed limit, if nonzero. In direct mode it holds a PWM duty on the forward or reverse
// leg, saturated at the PWM limit. A tick for an axis number beyond the configured count leaves
// all state alone and gives a result that holds only the axis number. The block is a
// five-register pipeline: the input register, the error stage, the gain multiplier stage, the
// accumulator stage and the output register. It takes one transaction every clock cycle while
// the output side does not stall, and holds results while it stalls. The per-axis error
// history is updated as a tick leaves the error stage, and the accumulator as it leaves the
// accumulator stage. Ticks for the same axis can therefore follow one another in consecutive
// cycles without forwarding. Configuration is written through a plain write port; the user
// must write it only while the pipeline is empty, and the block itself does not enforce this.
module incremental_pid_position_loop_core #(
    parameter int AXES           = ipid_pkg::DEFAULT_AXES,
    parameter int POSITION_WIDTH = ipid_pkg::DEFAULT_POSITION_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ipid_pkg::pid_in_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ipid_pkg::pid_out_t                  out_data,
    input  logic                                cfg_we,
    input  logic [ipid_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ipid_pkg::*;
    `include "incremental_pid_position_loop_core_assert.svh"

    // Index width for the per-axis stores, and the stored error width. Only the low 32 bits of
    // an error ever reach the accumulator, so a wider error is kept only to 32 bits.
    localparam int IDX_W   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int ERR_W   = (POSITION_WIDTH + 1 < ACC_W) ? POSITION_WIDTH + 1 : ACC_W;
    localparam int RANGE_W = 4;

    // Configuration registers.
    logic [GAIN_W-1:0]         gain_p_reg;
    logic [GAIN_W-1:0]         gain_i_reg;
    logic [GAIN_W-1:0]         gain_d_reg;
    logic [MODE_W-1:0]         loop_mode_reg;
    logic [PWM_W-1:0]          pwm_limit_reg;
    logic signed [SPEED_W-1:0] speed_limit_reg [LIMIT_REGS];

    // Per-axis state.
    logic [ERR_W-1:0] last_error_reg  [AXES];
    logic [ERR_W-1:0] prior_error_reg [AXES];
    logic [ACC_W-1:0] accum_reg       [AXES];

    // Pipeline stage registers.
    logic                    s1_valid_reg;
    logic [AXIS_W-1:0]       s1_axis_reg;
    logic signed [POS_W-1:0] s1_target_reg;
    logic signed [POS_W-1:0] s1_measured_reg;

    logic                    s2_valid_reg;
    logic                    s2_ok_reg;
    logic [AXIS_W-1:0]       s2_axis_reg;
    logic [ACC_W-1:0]        s2_e_reg;
    logic [ACC_W-1:0]        s2_d1_reg;
    logic [ACC_W-1:0]        s2_d2_reg;

    logic                    s3_valid_reg;
    logic                    s3_ok_reg;
    logic [AXIS_W-1:0]       s3_axis_reg;
    logic [ACC_W-1:0]        s3_pp_reg;
    logic [ACC_W-1:0]        s3_pi_reg;
    logic [ACC_W-1:0]        s3_pd_reg;

    logic                    s4_valid_reg;
    logic                    s4_ok_reg;
    logic [AXIS_W-1:0]       s4_axis_reg;
    logic signed [ACC_W-1:0] s4_acc_reg;

    logic                    out_valid_reg;
    pid_out_t                out_reg;
    pid_out_t                out_next;

    // Flow control: a stage may take a new transaction when it is empty or is handing its
    // own transaction on in the same cycle.
    logic out_ready;
    logic s4_ready;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_accept;
    logic s1_move;
    logic s2_move;
    logic s3_move;
    logic s4_move;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign s2_move   = s2_valid_reg && s3_ready;
    assign s3_move   = s3_valid_reg && s4_ready;
    assign s4_move   = s4_valid_reg && out_ready;

    // Error stage. The positions are taken as POSITION_WIDTH-bit two's complement values,
    // and the error is one bit wider so that it never overflows.
    logic [POSITION_WIDTH-1:0] s1_tp;
    logic [POSITION_WIDTH-1:0] s1_mp;
    logic [POSITION_WIDTH:0]   s1_e_full;
    logic [ACC_W-1:0]          s1_e;
    logic [ACC_W-1:0]          s1_e1;
    logic [ACC_W-1:0]          s1_e2;
    logic                      s1_ok;
    logic [IDX_W-1:0]          s1_idx;

    always_comb
    begin
        s1_tp     = POSITION_WIDTH'($unsigned(s1_target_reg));
        s1_mp     = POSITION_WIDTH'($unsigned(s1_measured_reg));
        s1_e_full = {s1_tp[POSITION_WIDTH-1], s1_tp} - {s1_mp[POSITION_WIDTH-1], s1_mp};
        s1_e      = ACC_W'($signed(s1_e_full));
        s1_ok     = ({2'b00, s1_axis_reg} < RANGE_W'(AXES));
        s1_idx    = IDX_W'(s1_axis_reg);
        s1_e1     = '0;
        s1_e2     = '0;
        if (s1_ok)
        begin
            s1_e1 = ACC_W'($signed(last_error_reg[s1_idx]));
            s1_e2 = ACC_W'($signed(prior_error_reg[s1_idx]));
        end
    end

    // Multiplier stage. The products are needed only modulo 2^32, so an unsigned multiply of
    // the two's complement differences gives the right bits.
    logic [ACC_W-1:0] s2_pp;
    logic [ACC_W-1:0] s2_pi;
    logic [ACC_W-1:0] s2_pd;

    assign s2_pp = s2_d1_reg * ACC_W'(gain_p_reg);
    assign s2_pi = s2_e_reg  * ACC_W'(gain_i_reg);
    assign s2_pd = s2_d2_reg * ACC_W'(gain_d_reg);

    // Accumulator stage.
    logic [IDX_W-1:0] s3_idx;
    logic [ACC_W-1:0] s3_acc_old;
    logic [ACC_W-1:0] s3_acc_new;

    always_comb
    begin
        s3_idx     = IDX_W'(s3_axis_reg);
        s3_acc_old = '0;
        if (s3_ok_reg)
        begin
            s3_acc_old = accum_reg[s3_idx];
        end
        s3_acc_new = s3_acc_old + s3_pp_reg + s3_pi_reg + s3_pd_reg;
    end

    // Output stage: velocity clamp or PWM leg selection.
    logic signed [SPEED_W-1:0] s4_speed;
    logic [SPEED_W:0]          s4_lim;
    logic signed [ACC_W:0]     s4_acc_x;
    logic signed [ACC_W:0]     s4_lim_x;
    logic signed [ACC_W:0]     s4_vel_x;
    logic [ACC_W-1:0]          s4_mag;
    logic [PWM_W-1:0]          s4_duty;

    always_comb
    begin
        s4_speed = '0;
        if ({1'b0, s4_axis_reg} < 3'(LIMIT_REGS))
        begin
            s4_speed = speed_limit_reg[s4_axis_reg];
        end
        s4_lim   = s4_speed[SPEED_W-1] ? ((SPEED_W + 1)'(0) - {s4_speed[SPEED_W-1], s4_speed})
                                       : {1'b0, s4_speed};
        s4_acc_x = {s4_acc_reg[ACC_W-1], s4_acc_reg};
        s4_lim_x = $signed((ACC_W + 1)'(s4_lim));
        s4_vel_x = s4_acc_x;
        if (s4_lim != '0)
        begin
            if (s4_acc_x > s4_lim_x)
            begin
                s4_vel_x = s4_lim_x;
            end
            else if (s4_acc_x < -s4_lim_x)
            begin
                s4_vel_x = -s4_lim_x;
            end
        end

        s4_mag  = s4_acc_reg[ACC_W-1] ? (ACC_W'(0) - s4_acc_reg) : s4_acc_reg;
        s4_duty = (s4_mag > ACC_W'(pwm_limit_reg)) ? pwm_limit_reg : s4_mag[PWM_W-1:0];

        out_next          = '0;
        out_next.axis_out = s4_axis_reg;
        if (s4_ok_reg)
        begin
            if (loop_mode_reg == MODE_VELOCITY)
            begin
                out_next.velocity_command = ACC_W'(s4_vel_x);
                out_next.velocity_valid   = 1'b1;
            end
            else if (loop_mode_reg == MODE_DIRECT && s4_acc_reg != '0)
            begin
                if (s4_acc_reg[ACC_W-1])
                begin
                    out_next.pwm_reverse = s4_duty;
                end
                else
                begin
                    out_next.pwm_forward = s4_duty;
                end
                out_next.pwm_valid = 1'b1;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= GAIN_P_RESET;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            loop_mode_reg <= MODE_DIRECT;
            pwm_limit_reg <= PWM_LIMIT_RESET;
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                speed_limit_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P:        gain_p_reg         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:        gain_i_reg         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:        gain_d_reg         <= cfg_data[GAIN_W-1:0];
                REG_LOOP_MODE:     loop_mode_reg      <= cfg_data[MODE_W-1:0];
                REG_PWM_LIMIT:     pwm_limit_reg      <= cfg_data[PWM_W-1:0];
                REG_SPEED_LIMIT_A: speed_limit_reg[0] <= $signed(cfg_data[SPEED_W-1:0]);
                REG_SPEED_LIMIT_B: speed_limit_reg[1] <= $signed(cfg_data[SPEED_W-1:0]);
                REG_SPEED_LIMIT_C: speed_limit_reg[2] <= $signed(cfg_data[SPEED_W-1:0]);
                default:           ;
            endcase
        end
    end

    // Per-axis state: the error history moves as a tick leaves the error stage, and the
    // accumulator as a tick leaves the accumulator stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                last_error_reg[i]  <= '0;
                prior_error_reg[i] <= '0;
                accum_reg[i]       <= '0;
            end
        end
        else
        begin
            if (s1_move && s1_ok)
            begin
                prior_error_reg[s1_idx] <= last_error_reg[s1_idx];
                last_error_reg[s1_idx]  <= ERR_W'(s1_e_full);
            end
            if (s3_move && s3_ok_reg)
            begin
                accum_reg[s3_idx] <= s3_acc_new;
            end
        end
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_axis_reg     <= in_data.axis;
            s1_target_reg   <= in_data.target_position;
            s1_measured_reg <= in_data.measured_position;
        end
        if (s1_move)
        begin
            s2_ok_reg   <= s1_ok;
            s2_axis_reg <= s1_axis_reg;
            s2_e_reg    <= s1_e;
            s2_d1_reg   <= s1_e - s1_e1;
            s2_d2_reg   <= s1_e - {s1_e1[ACC_W-2:0], 1'b0} + s1_e2;
        end
        if (s2_move)
        begin
            s3_ok_reg   <= s2_ok_reg;
            s3_axis_reg <= s2_axis_reg;
            s3_pp_reg   <= s2_pp;
            s3_pi_reg   <= s2_pi;
            s3_pd_reg   <= s2_pd;
        end
        if (s3_move)
        begin
            s4_ok_reg   <= s3_ok_reg;
            s4_axis_reg <= s3_axis_reg;
            s4_acc_reg  <= $signed(s3_acc_new);
        end
        if (s4_move)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A PWM result drives at most one leg, and never together with a velocity command. Both
    // legs are zero when the PWM limit is zero.
    `IPID_ASSERT_SAME(a_pwm_one_leg,
        out_valid && out_data.pwm_valid,
        !out_data.velocity_valid && ((out_data.pwm_forward == '0) || (out_data.pwm_reverse == '0)),
        "PWM result must drive at most one leg")

    // A PWM duty never exceeds the configured limit.
    `IPID_ASSERT_SAME(a_pwm_within_limit,
        out_valid && out_data.pwm_valid,
        (out_data.pwm_forward <= pwm_limit_reg) && (out_data.pwm_reverse <= pwm_limit_reg),
        "PWM duty above the configured limit")

    // A tick for an axis beyond the configured count gives a result with nothing but the axis.
    `IPID_ASSERT_SAME(a_out_of_range_empty,
        out_valid && ({2'b00, out_data.axis_out} >= RANGE_W'(AXES)),
        !out_data.velocity_valid && !out_data.pwm_valid && (out_data.velocity_command == '0),
        "result for an unknown axis carries data")

    // A result that leaves the output register is followed by the next stage's transaction.
    `IPID_ASSERT_NEXT(a_out_refill,
        out_valid && !out_stall && s4_valid_reg,
        out_valid,
        "output register lost a transaction from the accumulator stage")

endmodule
